// File: rtl/tdssm_pkg.sv
// ----------------------------------------------------------------------------
// tdssm_pkg
// Shared types, codes and the character-to-segment table of the display driver.
// ----------------------------------------------------------------------------
package tdssm_pkg;

  localparam int NUM_DIGITS_DEF = 3;
  localparam int ROW_DIGITS     = 3;
  localparam int SEG_W          = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 15;
  localparam int HALF_W         = 15;
  localparam int COUNT_W        = 16;
  localparam logic [9:0] NUM_SAT = 10'd999;
  localparam logic [HALF_W-1:0] BLINK_HALF_RST = 15'd100;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_UPPER_NUM = 3'd1,
    REQ_LOWER_NUM = 3'd2,
    REQ_UPPER_CHR = 3'd3,
    REQ_LOWER_CHR = 3'd4
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLINK_ENABLE = 2'd0,
    CFG_BLINK_HALF   = 2'd1
  } cfg_index_t;

  typedef logic [SEG_W-1:0] seg_t;

  typedef struct packed {
    logic                       tick;
    logic                       fail;
    logic                       wr_upper;
    logic                       wr_lower;
    logic [ROW_DIGITS-1:0][SEG_W-1:0] seg;
  } disp_cmd_t;

  localparam logic [7:0] SEG_ROM [128] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
    8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40,
    8'h9C, 8'hF0, 8'h00, 8'h00, 8'h08, 8'h02, 8'h00, 8'h00,
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
    8'hFE, 8'hF6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'hBC,
    8'h6E, 8'h60, 8'h70, 8'h00, 8'h1C, 8'h00, 8'hEC, 8'hFC,
    8'hCE, 8'hE6, 8'h8C, 8'hB6, 8'h1E, 8'h7C, 8'h00, 8'h00,
    8'h00, 8'h76, 8'h00, 8'h9C, 8'h00, 8'hF0, 8'h00, 8'h10,
    8'h04, 8'hEE, 8'h3E, 8'h1A, 8'h7A, 8'hDE, 8'h8E, 8'hBC,
    8'h2E, 8'h20, 8'h70, 8'h00, 8'h60, 8'h00, 8'hEC, 8'h3A,
    8'hCE, 8'hE6, 8'h8C, 8'hB6, 8'h1E, 8'h38, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // board wiring of the segment bits
  function automatic seg_t seg_permute(input seg_t s);
    seg_t p;
    p[0] = s[0];
    p[1] = s[1];
    p[6] = s[2];
    p[4] = s[3];
    p[3] = s[4];
    p[2] = s[5];
    p[7] = s[6];
    p[5] = s[7];
    return p;
  endfunction

  function automatic seg_t seg_encode(input logic [7:0] code);
    seg_t s;
    if (code[7]) begin
      s = '0;
    end else begin
      s = seg_permute(SEG_ROM[code[6:0]]);
    end
    return s;
  endfunction

endpackage

// File: rtl/tdssm_encoder.sv
// ----------------------------------------------------------------------------
// tdssm_encoder
// Decodes one registered item into a display command: number split into
// decimal digits, character lookup and the write filter.
// ----------------------------------------------------------------------------
module tdssm_encoder (
  input  logic [2:0]             req_type,
  input  logic [15:0]            number_value,
  input  logic [7:0]             char_first,
  input  logic [7:0]             char_second,
  input  logic [7:0]             char_third,
  input  logic                   write_override,
  input  logic                   system_failure,
  output tdssm_pkg::disp_cmd_t   cmd
);
  import tdssm_pkg::*;

  logic [9:0]  num_sat;
  logic [15:0] hun_prod;
  logic [3:0]  hun;
  logic [6:0]  rem_hun;
  logic [14:0] ten_prod;
  logic [3:0]  ten;
  logic [3:0]  one;
  logic        is_num;
  logic        wr_ok;
  logic [ROW_DIGITS-1:0][7:0] codes;

  // divide by 100 and by 10 through reciprocals, exact below 1000
  always_comb begin
    num_sat  = (number_value > 16'(NUM_SAT)) ? NUM_SAT : number_value[9:0];
    hun_prod = 16'(num_sat) * 16'd41;
    hun      = hun_prod[15:12];
    rem_hun  = 7'(num_sat - 10'(hun) * 10'd100);
    ten_prod = 15'(rem_hun) * 15'd205;
    ten      = ten_prod[14:11];
    one      = 4'(rem_hun - 7'(ten) * 7'd10);
  end

  always_comb begin
    cmd      = '0;
    is_num   = 1'b0;
    cmd.fail = system_failure;
    wr_ok    = !system_failure || write_override;
    unique case (req_type)
      REQ_TICK: begin
        cmd.tick = 1'b1;
      end
      REQ_UPPER_NUM: begin
        cmd.wr_upper = wr_ok;
        is_num       = 1'b1;
      end
      REQ_LOWER_NUM: begin
        cmd.wr_lower = wr_ok;
        is_num       = 1'b1;
      end
      REQ_UPPER_CHR: begin
        cmd.wr_upper = wr_ok;
      end
      REQ_LOWER_CHR: begin
        cmd.wr_lower = wr_ok;
      end
      default: begin
      end
    endcase
    if (is_num) begin
      codes[0] = {4'h3, hun};
      codes[1] = {4'h3, ten};
      codes[2] = {4'h3, one};
    end else begin
      codes[0] = char_first;
      codes[1] = char_second;
      codes[2] = char_third;
    end
    for (int k = 0; k < ROW_DIGITS; k++) begin
      cmd.seg[k] = seg_encode(codes[k]);
    end
  end

endmodule

// File: rtl/tdssm_display.sv
// ----------------------------------------------------------------------------
// tdssm_display
// Row storage, blink counter, digit scan and the result register.
// ----------------------------------------------------------------------------
module tdssm_display #(
  parameter int NUM_DIGITS = tdssm_pkg::NUM_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  tdssm_pkg::disp_cmd_t             cmd,
  input  logic                             blink_enable,
  input  logic [tdssm_pkg::HALF_W-1:0]     blink_half_ticks,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [15:0]                      out_shift_word,
  output logic [2:0]                       out_digit_enable
);
  import tdssm_pkg::*;

  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  seg_t upper_r     [NUM_DIGITS];
  seg_t upper_nxt   [NUM_DIGITS];
  seg_t lower_r     [NUM_DIGITS];
  seg_t lower_nxt   [NUM_DIGITS];
  seg_t shown_r     [NUM_DIGITS];
  seg_t shown_nxt   [NUM_DIGITS];
  logic [COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        word_r, word_nxt;
  logic [2:0]         en_r, en_nxt;
  logic [7:0]         onehot;
  logic               tick;

  assign tick = go && cmd.tick;

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      upper_nxt[k] = upper_r[k];
      lower_nxt[k] = lower_r[k];
      if (k < ROW_DIGITS) begin
        if (go && cmd.wr_upper) begin
          upper_nxt[k] = cmd.seg[k];
        end
        if (go && cmd.wr_lower) begin
          lower_nxt[k] = cmd.seg[k];
        end
      end
    end
  end

  // blink sequence
  always_comb begin
    count_inc = count_r + 1'b1;
    count_nxt = count_r;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      shown_nxt[k] = shown_r[k];
    end
    if (tick) begin
      if (blink_enable && !cmd.fail) begin
        count_nxt = count_inc;
        if (count_inc == {1'b0, blink_half_ticks}) begin
          for (int k = 0; k < NUM_DIGITS; k++) begin
            shown_nxt[k] = '0;
          end
        end else if ({1'b0, count_inc} == {1'b0, blink_half_ticks, 1'b0}) begin
          count_nxt = '0;
          for (int k = 0; k < NUM_DIGITS; k++) begin
            shown_nxt[k] = lower_r[k];
          end
        end
      end else begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
          shown_nxt[k] = lower_r[k];
        end
      end
    end
  end

  always_comb begin
    onehot        = 8'd1 << idx_r;
    idx_nxt       = idx_r;
    word_nxt      = word_r;
    en_nxt        = en_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (tick) begin
      word_nxt      = {shown_nxt[idx_r], upper_r[idx_r]};
      en_nxt        = onehot[2:0];
      out_valid_nxt = 1'b1;
      idx_nxt       = (idx_r == IDX_W'(NUM_DIGITS - 1)) ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        upper_r[k] <= '0;
        lower_r[k] <= '0;
        shown_r[k] <= '0;
      end
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        upper_r[k] <= upper_nxt[k];
        lower_r[k] <= lower_nxt[k];
        shown_r[k] <= shown_nxt[k];
      end
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    en_r   <= en_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_shift_word   = word_r;
  assign out_digit_enable = en_r;

endmodule

// File: rtl/three_digit_seven_segment_mux_top.sv
// ----------------------------------------------------------------------------
// three_digit_seven_segment_mux_top
// Two-row multiplexed seven-segment display driver with lower-row blink.
// ----------------------------------------------------------------------------
// Each item is accepted into the input register, decoded there and applied
// to the row, blink and scan state at the clock edge that lets it go, where a
// tick also loads its result into the output register, so a tick result passes
// the input register and then the output register. A new item is taken every
// cycle; only a tick waits, and only while an untaken result holds the output
// register. Scan and blink state update as the next item is taken, setting
// that rate. Write items give no result. Configuration is taken at any cycle and
// should be written while the block is idle.
module three_digit_seven_segment_mux_top #(
  parameter int NUM_DIGITS = tdssm_pkg::NUM_DIGITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_req_type,
  input  logic [15:0]                        in_number_value,
  input  logic [7:0]                         in_char_first,
  input  logic [7:0]                         in_char_second,
  input  logic [7:0]                         in_char_third,
  input  logic                               in_write_override,
  input  logic                               in_system_failure,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [15:0]                        out_shift_word,
  output logic [2:0]                         out_digit_enable,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tdssm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tdssm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tdssm_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  logic [2:0]        req_r;
  logic [15:0]       num_r;
  logic [7:0]        c0_r, c1_r, c2_r;
  logic              ovr_r, fail_r;
  logic              blink_en_r, blink_en_nxt;
  logic [HALF_W-1:0] half_r, half_nxt;
  logic              go;
  disp_cmd_t         cmd;

  // a tick waits only while an untaken result holds the output register
  assign go        = in_valid_r && (!cmd.tick || !out_valid || out_ready);
  assign in_ready  = !in_valid_r || go;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
    blink_en_nxt = blink_en_r;
    half_nxt     = half_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLINK_ENABLE: blink_en_nxt = cfg_wdata[0];
        CFG_BLINK_HALF:   half_nxt     = cfg_wdata[HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      blink_en_r <= 1'b0;
      half_r     <= BLINK_HALF_RST;
    end else begin
      in_valid_r <= in_valid_nxt;
      blink_en_r <= blink_en_nxt;
      half_r     <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r  <= in_req_type;
      num_r  <= in_number_value;
      c0_r   <= in_char_first;
      c1_r   <= in_char_second;
      c2_r   <= in_char_third;
      ovr_r  <= in_write_override;
      fail_r <= in_system_failure;
    end
  end

  tdssm_encoder u_encoder (
    .req_type       (req_r),
    .number_value   (num_r),
    .char_first     (c0_r),
    .char_second    (c1_r),
    .char_third     (c2_r),
    .write_override (ovr_r),
    .system_failure (fail_r),
    .cmd            (cmd)
  );

  tdssm_display #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_display (
    .clk              (clk),
    .rst_n            (rst_n),
    .go               (go),
    .cmd              (cmd),
    .blink_enable     (blink_en_r),
    .blink_half_ticks (half_r),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_shift_word   (out_shift_word),
    .out_digit_enable (out_digit_enable)
  );

endmodule
